// ===== rtl/vdh_pkg.sv =====
// Shared constants for the vertex dedup hash table.
// No dependencies; imported by the interfaces and by vertex_dedup_hash_table.
`default_nettype none

package vdh_pkg;

    localparam int DEF_MAX_VERTICES = 4096;
    localparam int DEF_NUM_BUCKETS  = 4096;

    localparam int WORD_W           = 32;
    localparam int WORDS_PER_VERTEX = 8;
    localparam int VERTEX_W         = WORD_W * WORDS_PER_VERTEX;
    localparam int KEY_W            = 12;
    localparam int INDEX_W          = 12;

    localparam logic ACT_ADD   = 1'b0;
    localparam logic ACT_CLEAR = 1'b1;

endpackage

`default_nettype wire

// ===== rtl/vdh_if.sv =====
// Valid/ready channel interfaces for the vertex dedup hash table.
// Depends on vdh_pkg for field widths.
`default_nettype none

interface vdh_in_if
    import vdh_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              action;
    logic [KEY_W-1:0]  position_key;
    logic [WORD_W-1:0] pos_x;
    logic [WORD_W-1:0] pos_y;
    logic [WORD_W-1:0] pos_z;
    logic [WORD_W-1:0] norm_x;
    logic [WORD_W-1:0] norm_y;
    logic [WORD_W-1:0] norm_z;
    logic [WORD_W-1:0] tex_u;
    logic [WORD_W-1:0] tex_v;

    modport source (
        output valid, action, position_key, pos_x, pos_y, pos_z,
               norm_x, norm_y, norm_z, tex_u, tex_v,
        input  ready
    );
    modport sink (
        input  valid, action, position_key, pos_x, pos_y, pos_z,
               norm_x, norm_y, norm_z, tex_u, tex_v,
        output ready
    );
endinterface

interface vdh_out_if
    import vdh_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [INDEX_W-1:0] vertex_index;
    logic               was_new;
    logic               store_full;

    modport source (
        output valid, vertex_index, was_new, store_full,
        input  ready
    );
    modport sink (
        input  valid, vertex_index, was_new, store_full,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/vdh_ram.sv =====
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`default_nettype none

module vdh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/vertex_dedup_hash_table.sv =====
// Vertex dedup hash table: bucket heads, vertex words and chain links in three RAMs.
// Depends on vdh_pkg, vdh_if (vdh_in_if, vdh_out_if) and vdh_ram.
// Flow: a clear finishes in S_IDLE; an add steps through S_REDUCE (R = key / NUM_BUCKETS subtraction
// steps, 0 when NUM_BUCKETS > 4095), S_HEAD and, for a valid head, S_WALK over L chain entries
// read through the shared 256-bit compare. One transaction in flight: input is taken only in S_IDLE.
// Reset clears state, count and output valid only; a bucket head is trusted if below the count and tagged.
`default_nettype none

module vertex_dedup_hash_table
    import vdh_pkg::*;
#(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES,
    parameter int NUM_BUCKETS  = DEF_NUM_BUCKETS
) (
    input wire logic  clk,
    input wire logic  rst_n,
    vdh_in_if.sink    vtx_in,
    vdh_out_if.source vtx_out
);

    localparam int IW     = $clog2(MAX_VERTICES);
    localparam int CW     = $clog2(MAX_VERTICES + 1);
    localparam int BW     = $clog2(NUM_BUCKETS);
    localparam int KXW    = (BW > KEY_W) ? BW : KEY_W;
    localparam int LINK_W = 1 + IW + BW;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_REDUCE = 2'd1;
    localparam logic [1:0] S_HEAD   = 2'd2;
    localparam logic [1:0] S_WALK   = 2'd3;

    logic [1:0]          state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [KXW-1:0]      kx_reg, kx_next;
    logic [VERTEX_W-1:0] words_reg, words_next;
    logic [IW-1:0]       cur_reg, cur_next;
    logic [IW-1:0]       head_idx_reg, head_idx_next;
    logic                first_reg, first_next;

    logic                out_valid_reg, out_valid_next;
    logic [INDEX_W-1:0]  out_index_reg, out_index_next;
    logic                out_new_reg, out_new_next;
    logic                out_full_reg, out_full_next;

    logic                in_fire;
    logic [BW-1:0]       bucket;

    logic                head_re;
    logic [IW-1:0]       head_rdata;
    logic                vs_re;
    logic [IW-1:0]       vs_raddr;
    logic [VERTEX_W-1:0] data_rdata;
    logic [LINK_W-1:0]   link_rdata;
    logic                ins_en;
    logic [LINK_W-1:0]   link_wdata;

    logic                miss;
    logic                miss_hv;
    logic [IW-1:0]       miss_head;
    logic                finish;
    logic [INDEX_W-1:0]  fin_index;
    logic                fin_new;
    logic                fin_full;

    logic                link_nv;
    logic [IW-1:0]       link_next;
    logic [BW-1:0]       link_tag;
    logic                match;

    assign bucket    = kx_reg[BW-1:0];
    assign link_nv   = link_rdata[LINK_W-1];
    assign link_next = link_rdata[IW+BW-1:BW];
    assign link_tag  = link_rdata[BW-1:0];
    assign match     = (data_rdata == words_reg);

    assign vtx_in.ready = (state_reg == S_IDLE) && (!out_valid_reg || vtx_out.ready);
    assign in_fire      = vtx_in.valid && vtx_in.ready;

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        kx_next       = kx_reg;
        words_next    = words_reg;
        cur_next      = cur_reg;
        head_idx_next = head_idx_reg;
        first_next    = first_reg;
        head_re       = 1'b0;
        vs_re         = 1'b0;
        vs_raddr      = cur_reg;
        miss          = 1'b0;
        miss_hv       = 1'b0;
        miss_head     = head_idx_reg;
        finish        = 1'b0;
        fin_index     = '0;
        fin_new       = 1'b0;
        fin_full      = 1'b0;
        ins_en        = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (vtx_in.action == ACT_CLEAR)
                    begin
                        count_next = '0;
                        finish     = 1'b1;
                    end
                    else
                    begin
                        kx_next    = KXW'(vtx_in.position_key);
                        words_next = {vtx_in.tex_v, vtx_in.tex_u, vtx_in.norm_z,
                                      vtx_in.norm_y, vtx_in.norm_x, vtx_in.pos_z,
                                      vtx_in.pos_y, vtx_in.pos_x};
                        state_next = S_REDUCE;
                    end
                end
            end
            S_REDUCE:
            begin
                // key modulo bucket count by repeated subtraction
                if ({1'b0, kx_reg} >= (KXW + 1)'(NUM_BUCKETS))
                begin
                    kx_next = kx_reg - KXW'(NUM_BUCKETS);
                end
                else
                begin
                    head_re    = 1'b1;
                    state_next = S_HEAD;
                end
            end
            S_HEAD:
            begin
                head_idx_next = head_rdata;
                if (CW'(head_rdata) < count_reg)
                begin
                    vs_re      = 1'b1;
                    vs_raddr   = head_rdata;
                    cur_next   = head_rdata;
                    first_next = 1'b1;
                    state_next = S_WALK;
                end
                else
                begin
                    miss      = 1'b1;
                    miss_head = head_rdata;
                end
            end
            S_WALK:
            begin
                if (first_reg && (link_tag != bucket))
                begin
                    // stale head left over from before a clear
                    miss = 1'b1;
                end
                else if (match)
                begin
                    finish    = 1'b1;
                    fin_index = INDEX_W'(cur_reg);
                end
                else if (link_nv && (CW'(link_next) < count_reg))
                begin
                    vs_re      = 1'b1;
                    vs_raddr   = link_next;
                    cur_next   = link_next;
                    first_next = 1'b0;
                end
                else
                begin
                    miss    = 1'b1;
                    miss_hv = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (miss)
        begin
            finish = 1'b1;
            if (count_reg >= CW'(MAX_VERTICES))
            begin
                fin_full = 1'b1;
            end
            else
            begin
                ins_en     = 1'b1;
                fin_new    = 1'b1;
                fin_index  = INDEX_W'(count_reg);
                count_next = count_reg + 1'b1;
            end
        end

        if (finish)
        begin
            state_next = S_IDLE;
        end
    end

    assign link_wdata = {miss_hv, miss_head, bucket};

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_index_next = out_index_reg;
        out_new_next   = out_new_reg;
        out_full_next  = out_full_reg;
        if (vtx_out.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (finish)
        begin
            out_valid_next = 1'b1;
            out_index_next = fin_index;
            out_new_next   = fin_new;
            out_full_next  = fin_full;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kx_reg        <= kx_next;
        words_reg     <= words_next;
        cur_reg       <= cur_next;
        head_idx_reg  <= head_idx_next;
        first_reg     <= first_next;
        out_index_reg <= out_index_next;
        out_new_reg   <= out_new_next;
        out_full_reg  <= out_full_next;
    end

    assign vtx_out.valid        = out_valid_reg;
    assign vtx_out.vertex_index = out_index_reg;
    assign vtx_out.was_new      = out_new_reg;
    assign vtx_out.store_full   = out_full_reg;

    vdh_ram #(
        .WIDTH (IW),
        .DEPTH (NUM_BUCKETS)
    ) u_head_ram (
        .clk   (clk),
        .we    (ins_en),
        .waddr (bucket),
        .wdata (count_reg[IW-1:0]),
        .re    (head_re),
        .raddr (bucket),
        .rdata (head_rdata)
    );

    vdh_ram #(
        .WIDTH (VERTEX_W),
        .DEPTH (MAX_VERTICES)
    ) u_data_ram (
        .clk   (clk),
        .we    (ins_en),
        .waddr (count_reg[IW-1:0]),
        .wdata (words_reg),
        .re    (vs_re),
        .raddr (vs_raddr),
        .rdata (data_rdata)
    );

    vdh_ram #(
        .WIDTH (LINK_W),
        .DEPTH (MAX_VERTICES)
    ) u_link_ram (
        .clk   (clk),
        .we    (ins_en),
        .waddr (count_reg[IW-1:0]),
        .wdata (link_wdata),
        .re    (vs_re),
        .raddr (vs_raddr),
        .rdata (link_rdata)
    );

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_VERTICES))
        else $error("vertex count beyond store depth");

    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        ins_en |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("insert did not advance vertex count");

    a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |-> (CW'(cur_reg) < count_reg))
        else $error("chain walk reached an unallocated entry");

    a_full_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (finish && fin_full) |-> (count_reg == CW'(MAX_VERTICES)))
        else $error("store full reported with free entries");
`endif

endmodule

`default_nettype wire
